// ===== sv/gaussian_blur_reduce_unit_assert.svh =====
// Assertion macros for the blur/reduce unit checkers.
// Needs nothing but a clock and an active-low reset in scope of the caller.
`ifndef GAUSSIAN_BLUR_REDUCE_UNIT_ASSERT_SVH
`define GAUSSIAN_BLUR_REDUCE_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is low.
`define GBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gbr check failed");

// Next-cycle implication, off while reset is low.
`define GBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gbr check failed");

`endif

// ===== sv/gbr_pkg.sv =====
// Shared constants, types and register codes of the blur/reduce unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gbr_pkg;
    localparam int CH_BITS    = 16;
    localparam int NUM_CH     = 3;
    localparam int TAPS       = 5;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int SLOTS      = 4;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int ADDR_W     = SLOT_W + COL_W;
    localparam int DEPTH      = SLOTS * MAX_WIDTH;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC       = 15;

    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CENTER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_NEAR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FAR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATE    = 3'd5;

    typedef logic [NUM_CH-1:0][CH_BITS-1:0] t_pix;

    typedef struct packed {
        t_pix             pix;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_res;
endpackage
`default_nettype wire

// ===== sv/gbr_pix_if.sv =====
// Input pixel channel: valid/ready handshake with one RGB pixel per word.
// Uses gbr_pkg for the channel width.
`timescale 1ns / 1ps
`default_nettype none
interface gbr_pix_if;
    logic                        valid;
    logic                        ready;
    logic [gbr_pkg::CH_BITS-1:0] red_in;
    logic [gbr_pkg::CH_BITS-1:0] green_in;
    logic [gbr_pkg::CH_BITS-1:0] blue_in;

    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface
`default_nettype wire

// ===== sv/gbr_res_if.sv =====
// Result channel: valid/ready handshake with one filtered pixel per word.
// Uses gbr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface gbr_res_if;
    logic                        valid;
    logic                        ready;
    logic [gbr_pkg::CH_BITS-1:0] red_out;
    logic [gbr_pkg::CH_BITS-1:0] green_out;
    logic [gbr_pkg::CH_BITS-1:0] blue_out;
    logic [gbr_pkg::COL_W-1:0]   out_col;
    logic [gbr_pkg::ROW_W-1:0]   out_row;
    logic                        run_last;
    logic                        frame_done;

    modport source (output valid, red_out, green_out, blue_out, out_col, out_row,
                    run_last, frame_done, input ready);
    modport sink (input valid, red_out, green_out, blue_out, out_col, out_row,
                  run_last, frame_done, output ready);
endinterface
`default_nettype wire

// ===== sv/gaussian_blur_reduce_unit.sv =====
// Blur/reduce unit: 5x5 separable Gaussian with edge replication and 2:1 decimation.
// Top level; uses gbr_pkg, gbr_pix_if, gbr_res_if and gbr_filt.
//
// Usage:
//   i_pix carries RGB pixels of a frame in raster order, o_res the filtered
//   pixels with their (optionally halved) coordinates, run_last on the final
//   word caused by an input and frame_done on the last word of a frame.
//   User writes config (size, Q15 weights, decimate) only while idle; not enforced.
// Sequence:
//   One pixel is taken, then each finished column is worked through: one
//   horizontal filter pass, four reads of the line store, one vertical pass
//   plus hand-off per finished row, and a write back. An ordinary pixel
//   finishes at most one column and row, a pixel at a frame corner three of each.
//   The single filter unit and single line store read port make this work serial.
// Reset and stall:
//   Reset clears counters, the pixel window and config to defaults; the line
//   store holds junk until rows are written. An output register and a one-word
//   hold stage sit before o_res; when o_res stalls, work pauses at the next
//   word, and i_pix takes a new pixel as soon as the current one is done.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_blur_reduce_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [gbr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gbr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    gbr_pix_if.sink                             i_pix,
    gbr_res_if.source                           o_res
);
    localparam int CW = gbr_pkg::COL_W;
    localparam int RW = gbr_pkg::ROW_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HREQ  = 4'd1;
    localparam logic [3:0] S_HWAIT = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_VREQ  = 4'd4;
    localparam logic [3:0] S_VWAIT = 4'd5;
    localparam logic [3:0] S_EMIT  = 4'd6;
    localparam logic [3:0] S_WR    = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]    r_state;
    logic [CW:0]   r_img_width;
    logic [RW:0]   r_img_height;
    logic [gbr_pkg::CH_BITS-1:0] r_coef_center, r_coef_near, r_coef_far;
    logic          r_decimate;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    gbr_pkg::t_pix r_rw [gbr_pkg::SLOTS];
    gbr_pkg::t_pix r_cur, r_h, r_v;
    gbr_pkg::t_pix r_rowbuf [gbr_pkg::SLOTS];
    logic [CW-1:0] r_c, r_x, r_x_last;
    logic [RW-1:0] r_r, r_y, r_y_first, r_y_last;
    logic          r_lastc, r_lastr, r_has_y;
    logic [2:0]    r_rq;
    logic          r_pend_v, r_ov;
    gbr_pkg::t_res r_pend;
    gbr_pkg::t_res r_out;
    logic          r_out_last, r_out_done;

    gbr_pkg::t_pix mem [gbr_pkg::DEPTH];
    gbr_pkg::t_pix r_rd_data;
    logic [gbr_pkg::ADDR_W-1:0] rd_addr, wr_addr;
    logic          mem_we;

    logic [CW:0]   width_eff, keep_w;
    logic [RW:0]   height_eff, keep_h;
    logic          lastc, lastr, has_x, has_y, kept, out_free, accept, out_load;
    logic [CW-1:0] x_first, x_last;
    logic [RW-1:0] y_first, y_last;
    logic [gbr_pkg::SLOT_W-1:0] rd_slot;

    logic signed [CW+1:0] he, hd;
    logic signed [RW+1:0] ve, vd;
    logic [2:0]    ho, vo;
    gbr_pkg::t_pix htap [gbr_pkg::TAPS];
    gbr_pkg::t_pix vtap [gbr_pkg::TAPS];
    gbr_pkg::t_pix ftap [gbr_pkg::TAPS];
    logic          filt_go, filt_ok;
    gbr_pkg::t_pix filt_pix;
    gbr_pkg::t_res new_res;

    // clamp frame size to the supported range
    always_comb begin
        if (r_img_width == '0) begin
            width_eff = (CW+1)'(1);
        end else if (r_img_width > (CW+1)'(gbr_pkg::MAX_WIDTH)) begin
            width_eff = (CW+1)'(gbr_pkg::MAX_WIDTH);
        end else begin
            width_eff = r_img_width;
        end
        if (r_img_height == '0) begin
            height_eff = (RW+1)'(1);
        end else if (r_img_height > (RW+1)'(gbr_pkg::MAX_HEIGHT)) begin
            height_eff = (RW+1)'(gbr_pkg::MAX_HEIGHT);
        end else begin
            height_eff = r_img_height;
        end
        keep_w = {width_eff[CW:1], 1'b0};
        keep_h = {height_eff[RW:1], 1'b0};
        lastc  = {1'b0, r_col} >= width_eff - (CW+1)'(1);
        lastr  = {1'b0, r_row} >= height_eff - (RW+1)'(1);
        has_x  = lastc || (r_col >= CW'(2));
        has_y  = lastr || (r_row >= RW'(2));
        x_first = (r_col >= CW'(2)) ? r_col - CW'(2) : '0;
        x_last  = lastc ? r_col : r_col - CW'(2);
        y_first = (r_row >= RW'(2)) ? r_row - RW'(2) : '0;
        y_last  = lastr ? r_row : r_row - RW'(2);
    end

    // horizontal taps: offset back from the newest pixel of the row
    always_comb begin
        he = '0;
        hd = '0;
        ho = '0;
        for (int k = 0; k < gbr_pkg::TAPS; k++) begin
            he = $signed({2'b00, r_x}) + $signed((CW+2)'(k)) - $signed((CW+2)'(2));
            hd = $signed({2'b00, r_c}) - he;
            if (he < 0) begin
                ho = r_c[2:0];
            end else if (hd < 0) begin
                ho = '0;
            end else begin
                ho = hd[2:0];
            end
            htap[k] = (ho == 3'd0) ? r_cur : r_rw[2'(ho - 3'd1)];
        end
    end

    // vertical taps: rows back from the current row, current row from r_h
    always_comb begin
        ve = '0;
        vd = '0;
        vo = '0;
        for (int k = 0; k < gbr_pkg::TAPS; k++) begin
            ve = $signed({2'b00, r_y}) + $signed((RW+2)'(k)) - $signed((RW+2)'(2));
            vd = $signed({2'b00, r_r}) - ve;
            if (ve < 0) begin
                vo = r_r[2:0];
            end else if (vd < 0) begin
                vo = '0;
            end else begin
                vo = vd[2:0];
            end
            vtap[k] = (vo == 3'd0) ? r_h : r_rowbuf[2'(vo - 3'd1)];
        end
    end

    always_comb begin
        for (int k = 0; k < gbr_pkg::TAPS; k++) begin
            ftap[k] = (r_state == S_HREQ) ? htap[k] : vtap[k];
        end
    end

    assign filt_go = (r_state == S_HREQ) || (r_state == S_VREQ);

    gbr_filt u_filt (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (filt_go),
        .i_taps        (ftap),
        .i_coef_center (r_coef_center),
        .i_coef_near   (r_coef_near),
        .i_coef_far    (r_coef_far),
        .o_valid       (filt_ok),
        .o_pix         (filt_pix)
    );

    assign rd_slot = r_r[gbr_pkg::SLOT_W-1:0] - gbr_pkg::SLOT_W'(r_rq)
                   - gbr_pkg::SLOT_W'(1);
    assign rd_addr = {rd_slot, r_x};
    assign wr_addr = {r_r[gbr_pkg::SLOT_W-1:0], r_x};
    assign mem_we  = (r_state == S_WR);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= r_h;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        kept = !r_decimate
            || (!r_x[0] && !r_y[0] && ({1'b0, r_x} < keep_w) && ({1'b0, r_y} < keep_h));
        new_res.pix = r_v;
        new_res.col = r_decimate ? {1'b0, r_x[CW-1:1]} : r_x;
        new_res.row = r_decimate ? {1'b0, r_y[RW-1:1]} : r_y;
    end

    assign out_free = !r_ov || o_res.ready;
    assign accept   = i_pix.valid && (r_state == S_IDLE);
    // move the held word into the output register
    assign out_load = r_pend_v && out_free
                   && (((r_state == S_EMIT) && kept) || (r_state == S_FIN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_img_width   <= (CW+1)'(640);
            r_img_height  <= (RW+1)'(480);
            r_coef_center <= 16'd13194;
            r_coef_near   <= 16'd8002;
            r_coef_far    <= 16'd1785;
            r_decimate    <= 1'b1;
            r_col         <= '0;
            r_row         <= '0;
            r_pend_v      <= 1'b0;
            r_ov          <= 1'b0;
            for (int i = 0; i < gbr_pkg::SLOTS; i++) begin
                r_rw[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gbr_pkg::CFG_IMG_WIDTH:   r_img_width   <= i_cfg_data[CW:0];
                    gbr_pkg::CFG_IMG_HEIGHT:  r_img_height  <= i_cfg_data[RW:0];
                    gbr_pkg::CFG_COEF_CENTER: r_coef_center <= i_cfg_data;
                    gbr_pkg::CFG_COEF_NEAR:   r_coef_near   <= i_cfg_data;
                    gbr_pkg::CFG_COEF_FAR:    r_coef_far    <= i_cfg_data;
                    gbr_pkg::CFG_DECIMATE:    r_decimate    <= i_cfg_data[0];
                    default: ;
                endcase
            end

            r_ov <= out_load || (r_ov && !o_res.ready);

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cur[gbr_pkg::CH_RED]   <= i_pix.red_in;
                        r_cur[gbr_pkg::CH_GREEN] <= i_pix.green_in;
                        r_cur[gbr_pkg::CH_BLUE]  <= i_pix.blue_in;
                        r_c       <= r_col;
                        r_r       <= r_row;
                        r_lastc   <= lastc;
                        r_lastr   <= lastr;
                        r_x       <= x_first;
                        r_x_last  <= x_last;
                        r_y_first <= y_first;
                        r_y_last  <= y_last;
                        r_has_y   <= has_y;
                        r_state   <= has_x ? S_HREQ : S_FIN;
                    end
                end
                S_HREQ: begin
                    r_state <= S_HWAIT;
                end
                S_HWAIT: begin
                    if (filt_ok) begin
                        r_h     <= filt_pix;
                        r_rq    <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // read data arrives in the cycle after its address
                    if (r_rq != 3'd0) begin
                        r_rowbuf[2'(r_rq - 3'd1)] <= r_rd_data;
                    end
                    if (r_rq == 3'(gbr_pkg::SLOTS)) begin
                        r_y     <= r_y_first;
                        r_state <= r_has_y ? S_VREQ : S_WR;
                    end else begin
                        r_rq <= r_rq + 3'd1;
                    end
                end
                S_VREQ: begin
                    r_state <= S_VWAIT;
                end
                S_VWAIT: begin
                    if (filt_ok) begin
                        r_v     <= filt_pix;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // hold one word back so run_last can be set on the true last
                    if (!kept || !r_pend_v || out_free) begin
                        if (kept) begin
                            if (r_pend_v) begin
                                r_out      <= r_pend;
                                r_out_last <= 1'b0;
                                r_out_done <= 1'b0;
                            end
                            r_pend   <= new_res;
                            r_pend_v <= 1'b1;
                        end
                        if (r_y == r_y_last) begin
                            r_state <= S_WR;
                        end else begin
                            r_y     <= r_y + RW'(1);
                            r_state <= S_VREQ;
                        end
                    end
                end
                S_WR: begin
                    if (r_x == r_x_last) begin
                        r_state <= S_FIN;
                    end else begin
                        r_x     <= r_x + CW'(1);
                        r_state <= S_HREQ;
                    end
                end
                S_FIN: begin
                    if (!r_pend_v || out_free) begin
                        if (r_pend_v) begin
                            r_out      <= r_pend;
                            r_out_last <= 1'b1;
                            r_out_done <= r_lastc && r_lastr;
                            r_pend_v   <= 1'b0;
                        end
                        for (int i = gbr_pkg::SLOTS - 1; i > 0; i--) begin
                            r_rw[i] <= r_rw[i-1];
                        end
                        r_rw[0] <= r_cur;
                        if (r_lastc) begin
                            r_col <= '0;
                            r_row <= r_lastr ? '0 : r_r + RW'(1);
                        end else begin
                            r_col <= r_c + CW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_pix.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_ov;
    assign o_res.red_out    = r_out.pix[gbr_pkg::CH_RED];
    assign o_res.green_out  = r_out.pix[gbr_pkg::CH_GREEN];
    assign o_res.blue_out   = r_out.pix[gbr_pkg::CH_BLUE];
    assign o_res.out_col    = r_out.col;
    assign o_res.out_row    = r_out.row;
    assign o_res.run_last   = r_out_last;
    assign o_res.frame_done = r_out_done;
endmodule
`default_nettype wire

// ===== sv/gbr_filt.sv =====
// Shared 5-tap symmetric filter, three channel lanes, with tap, product and output registers.
// Uses gbr_pkg for pixel type and widths.
`timescale 1ns / 1ps
`default_nettype none
module gbr_filt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire gbr_pkg::t_pix               i_taps [gbr_pkg::TAPS],
    input  wire logic [gbr_pkg::CH_BITS-1:0] i_coef_center,
    input  wire logic [gbr_pkg::CH_BITS-1:0] i_coef_near,
    input  wire logic [gbr_pkg::CH_BITS-1:0] i_coef_far,
    output logic                             o_valid,
    output gbr_pkg::t_pix                    o_pix
);
    localparam int PW = 2 * gbr_pkg::CH_BITS + 1;
    localparam int SW = PW + 2;

    gbr_pkg::t_pix r_tap [gbr_pkg::TAPS];
    logic [PW-1:0]  r_pf [gbr_pkg::NUM_CH];
    logic [PW-1:0]  r_pn [gbr_pkg::NUM_CH];
    logic [PW-1:0]  r_pc [gbr_pkg::NUM_CH];
    logic           r_v0, r_v1, r_v2;
    gbr_pkg::t_pix  r_pix;
    logic [SW-1:0]  s_sum [gbr_pkg::NUM_CH];
    logic [SW-gbr_pkg::FRAC-1:0] s_sh [gbr_pkg::NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    // round half up, then saturate to the channel range
    always_comb begin
        for (int c = 0; c < gbr_pkg::NUM_CH; c++) begin
            s_sum[c] = SW'(r_pf[c]) + SW'(r_pn[c]) + SW'(r_pc[c])
                     + (SW'(1) << (gbr_pkg::FRAC - 1));
            s_sh[c]  = s_sum[c][SW-1:gbr_pkg::FRAC];
        end
    end

    function automatic gbr_pkg::t_pix o_pix_next();
        gbr_pkg::t_pix p;
        for (int c = 0; c < gbr_pkg::NUM_CH; c++) begin
            if (|s_sh[c][SW-gbr_pkg::FRAC-1:gbr_pkg::CH_BITS]) begin
                p[c] = '1;
            end else begin
                p[c] = s_sh[c][gbr_pkg::CH_BITS-1:0];
            end
        end
        return p;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_tap <= i_taps;
        end
        for (int c = 0; c < gbr_pkg::NUM_CH; c++) begin
            r_pf[c] <= PW'(i_coef_far) * (PW'(r_tap[0][c]) + PW'(r_tap[4][c]));
            r_pn[c] <= PW'(i_coef_near) * (PW'(r_tap[1][c]) + PW'(r_tap[3][c]));
            r_pc[c] <= PW'(i_coef_center) * PW'(r_tap[2][c]);
        end
        r_pix <= o_pix_next();
    end

    assign o_valid = r_v2;
    assign o_pix   = r_pix;
endmodule
`default_nettype wire

// ===== sv/gbr_checker.sv =====
// Port-level checks of the blur/reduce unit, bound to the top level.
// Uses gbr_pkg widths and the macros of gaussian_blur_reduce_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "gaussian_blur_reduce_unit_assert.svh"
module gbr_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [gbr_pkg::CH_BITS-1:0] i_red,
    input wire logic [gbr_pkg::CH_BITS-1:0] i_green,
    input wire logic [gbr_pkg::CH_BITS-1:0] i_blue,
    input wire logic [gbr_pkg::COL_W-1:0]   i_col,
    input wire logic [gbr_pkg::ROW_W-1:0]   i_row,
    input wire logic                        i_run_last,
    input wire logic                        i_frame_done
);
    localparam int WW = 3 * gbr_pkg::CH_BITS + gbr_pkg::COL_W + gbr_pkg::ROW_W + 2;

    logic [WW-1:0] word;
    logic          stalled;

    assign word    = {i_red, i_green, i_blue, i_col, i_row, i_run_last, i_frame_done};
    assign stalled = i_out_valid && !i_out_ready;

    `GBR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stalled, i_out_valid)
    `GBR_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, stalled, $stable(word))
    `GBR_ASSERT_NOW(a_done_is_last, i_clk, i_rst_n, i_out_valid && i_frame_done, i_run_last)
    `GBR_ASSERT_NOW(a_quiet_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !i_out_valid)
endmodule

bind gaussian_blur_reduce_unit gbr_checker u_gbr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_red        (o_res.red_out),
    .i_green      (o_res.green_out),
    .i_blue       (o_res.blue_out),
    .i_col        (o_res.out_col),
    .i_row        (o_res.out_row),
    .i_run_last   (o_res.run_last),
    .i_frame_done (o_res.frame_done)
);
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for gaussian_blur_reduce_unit: RGB frames go in, filtered
// pixels are predicted here and compared word by word. Depends on gbr_pkg,
// gbr_pix_if and gbr_res_if.
`timescale 1ns / 1ps
module tb_top;
    localparam int MW = gbr_pkg::MAX_WIDTH;

    typedef struct {
        logic [15:0] red, green, blue;
    } t_in_word;

    typedef struct {
        logic [15:0] red, green, blue;
        logic [10:0] col;
        logic [11:0] row;
        logic        last, done;
    } t_blur_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [gbr_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [gbr_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    gbr_pix_if pix_ch ();
    gbr_res_if res_ch ();

    gaussian_blur_reduce_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_pix(pix_ch.sink), .o_res(res_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow configuration and state
    int unsigned width_q, height_q, coef_c, coef_n, coef_f, decim_q;
    int unsigned col_cnt, row_cnt;
    logic [15:0] win_q [4][3];
    logic [15:0] hline [4*MW][3];

    t_in_word pixel_queue[$];
    t_blur_word blur_expect[$];
    int send_idle_pct = 0, recv_stall_pct = 0;
    bit hold_off = 0;
    bit hold_start = 0;
    bit pix_taken = 0;
    int errors = 0, words_seen = 0, pixels_sent = 0;
    longint cycles = 0;

    function automatic logic [15:0] tap5(int unsigned a0, int unsigned a1,
                                         int unsigned a2, int unsigned a3,
                                         int unsigned a4);
        longint unsigned s;
        s = longint'(coef_f) * (a0 + a4) + longint'(coef_n) * (a1 + a3)
            + longint'(coef_c) * a2;
        s = (s + 16384) >> 15;
        return (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    function automatic int clampv(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Advance the shadow state by one pixel and queue the words it finishes.
    task automatic predict_blur(t_in_word p);
        int w, h, c, r, kw, kh, nx, ny, cnt, o, t, x, y;
        int xs[3], ys[3];
        bit lc, lr;
        logic [15:0] cur[3], hv[3], vv[3];
        int unsigned a[5];
        t_blur_word wd;
        t_blur_word batch[$];
        w = clampv(width_q, 1, MW);
        h = clampv(height_q, 1, 4096);
        c = col_cnt; r = row_cnt;
        lc = c >= w - 1; lr = r >= h - 1;
        kw = (w / 2) * 2; kh = (h / 2) * 2;
        cur[0] = p.red; cur[1] = p.green; cur[2] = p.blue;
        nx = 0; ny = 0;
        if (c >= 2) xs[nx++] = c - 2;
        if (lc) begin
            if (c >= 1) xs[nx++] = c - 1;
            xs[nx++] = c;
        end
        if (r >= 2) ys[ny++] = r - 2;
        if (lr) begin
            if (r >= 1) ys[ny++] = r - 1;
            ys[ny++] = r;
        end
        for (int i = 0; i < nx; i++) begin
            x = xs[i];
            for (int ch = 0; ch < 3; ch++) begin
                for (int k = 0; k < 5; k++) begin
                    o = c - clampv(x + k - 2, 0, c);
                    a[k] = (o == 0) ? cur[ch] : win_q[(o - 1) & 3][ch];
                end
                hv[ch] = tap5(a[0], a[1], a[2], a[3], a[4]);
            end
            for (int j = 0; j < ny; j++) begin
                y = ys[j];
                for (int ch = 0; ch < 3; ch++) begin
                    for (int k = 0; k < 5; k++) begin
                        t = clampv(y + k - 2, 0, r);
                        a[k] = (t == r) ? hv[ch] : hline[(t & 3) * MW + x][ch];
                    end
                    vv[ch] = tap5(a[0], a[1], a[2], a[3], a[4]);
                end
                if (decim_q && ((x & 1) || (y & 1) || x >= kw || y >= kh)) continue;
                wd.red = vv[0]; wd.green = vv[1]; wd.blue = vv[2];
                wd.col = 11'(decim_q ? x >> 1 : x);
                wd.row = 12'(decim_q ? y >> 1 : y);
                wd.last = 0; wd.done = 0;
                batch = {batch, wd};
            end
            for (int ch = 0; ch < 3; ch++) hline[(r & 3) * MW + x][ch] = hv[ch];
        end
        cnt = batch.size();
        if (cnt > 0) begin
            batch[cnt-1].last = 1;
            batch[cnt-1].done = lc && lr;
        end
        foreach (batch[i]) blur_expect = {blur_expect, batch[i]};
        for (int k = 3; k > 0; k--) win_q[k] = win_q[k-1];
        win_q[0] = cur;
        if (lc) begin
            col_cnt = 0;
            row_cnt = lr ? 0 : (r + 1) & 12'hFFF;
        end else begin
            col_cnt = (c + 1) & 11'h7FF;
        end
    endtask

    // note each accepted input word at the rising edge
    always @(posedge i_clk) begin
        pix_taken <= i_rst_n && pix_ch.valid && pix_ch.ready;
    end

    // driver: offer words at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (pix_taken) begin
                predict_blur(pixel_queue.pop_front());
                pixels_sent <= pixels_sent + 1;
            end
            if (pix_ch.valid && !pix_taken) begin
                // hold the offered word until it is taken
            end else if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                pix_ch.valid <= 1'b1;
                pix_ch.red_in <= pixel_queue[0].red;
                pix_ch.green_in <= pixel_queue[0].green;
                pix_ch.blue_in <= pixel_queue[0].blue;
            end else begin
                pix_ch.valid <= 1'b0;
            end
            res_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver stall, timed here
    always @(posedge hold_start) begin
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // monitor: sample at the rising edge
    always @(posedge i_clk) begin
        t_blur_word e;
        cycles <= cycles + 1;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            words_seen <= words_seen + 1;
            if (blur_expect.size() == 0) begin
                $error("unexpected word col=%0d row=%0d", res_ch.out_col, res_ch.out_row);
                errors++;
            end else begin
                e = blur_expect.pop_front();
                if (res_ch.red_out !== e.red) begin
                    $error("red_out exp %0d got %0d", e.red, res_ch.red_out); errors++;
                end
                if (res_ch.green_out !== e.green) begin
                    $error("green_out exp %0d got %0d", e.green, res_ch.green_out); errors++;
                end
                if (res_ch.blue_out !== e.blue) begin
                    $error("blue_out exp %0d got %0d", e.blue, res_ch.blue_out); errors++;
                end
                if (res_ch.out_col !== e.col) begin
                    $error("out_col exp %0d got %0d", e.col, res_ch.out_col); errors++;
                end
                if (res_ch.out_row !== e.row) begin
                    $error("out_row exp %0d got %0d", e.row, res_ch.out_row); errors++;
                end
                if (res_ch.run_last !== e.last) begin
                    $error("run_last exp %0d got %0d", e.last, res_ch.run_last); errors++;
                end
                if (res_ch.frame_done !== e.done) begin
                    $error("frame_done exp %0d got %0d", e.done, res_ch.frame_done); errors++;
                end
            end
        end
        if (cycles > 3000000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [gbr_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val[gbr_pkg::CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            gbr_pkg::CFG_IMG_WIDTH:   width_q = val & 12'hFFF;
            gbr_pkg::CFG_IMG_HEIGHT:  height_q = val & 13'h1FFF;
            gbr_pkg::CFG_COEF_CENTER: coef_c = val & 16'hFFFF;
            gbr_pkg::CFG_COEF_NEAR:   coef_n = val & 16'hFFFF;
            gbr_pkg::CFG_COEF_FAR:    coef_f = val & 16'hFFFF;
            gbr_pkg::CFG_DECIMATE:    decim_q = val & 1;
            default: ;
        endcase
    endtask

    task automatic set_frame(int w, int h, int c, int n, int f, int d);
        write_reg(gbr_pkg::CFG_IMG_WIDTH, w);
        write_reg(gbr_pkg::CFG_IMG_HEIGHT, h);
        write_reg(gbr_pkg::CFG_COEF_CENTER, c);
        write_reg(gbr_pkg::CFG_COEF_NEAR, n);
        write_reg(gbr_pkg::CFG_COEF_FAR, f);
        write_reg(gbr_pkg::CFG_DECIMATE, d);
    endtask

    // Queue whole frames so no unwritten line store row is ever used.
    task automatic queue_frames(int w, int h, int frames, bit extremes);
        t_in_word p;
        for (int i = 0; i < w * h * frames; i++) begin
            if (extremes) begin
                p.red = (i % 2) ? 16'hFFFF : 16'h0000;
                p.green = (i % 3) ? 16'h0000 : 16'hFFFF;
                p.blue = 16'h1 << (i % 16);
            end else begin
                p.red = 16'($urandom); p.green = 16'($urandom); p.blue = 16'($urandom);
            end
            pixel_queue = {pixel_queue, p};
        end
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        while ((pixel_queue.size() > 0 || pix_ch.valid || blur_expect.size() > 0)
               && guard < 2000000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        int w, h;
        pix_ch.valid = 1'b0;
        pix_ch.red_in = '0; pix_ch.green_in = '0; pix_ch.blue_in = '0;
        res_ch.ready = 1'b0;
        width_q = 640; height_q = 480; coef_c = 13194; coef_n = 8002; coef_f = 1785;
        decim_q = 1; col_cnt = 0; row_cnt = 0;
        foreach (win_q[k, ch]) win_q[k][ch] = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme pixels, plain blur, then weights that saturate
        set_frame(4, 3, 13194, 8002, 1785, 0);
        queue_frames(4, 3, 1, 1);
        wait_idle();
        set_frame(3, 3, 32768, 32768, 32768, 1);
        queue_frames(3, 3, 1, 1);
        wait_idle();
        // width of one while decimating emits nothing; zero weights
        set_frame(1, 3, 0, 0, 0, 1);
        queue_frames(1, 3, 1, 1);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 87 : 34) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 87 : 34) : 0;
            w = $urandom_range(3, 7); h = $urandom_range(3, 6);
            set_frame(w, h, $urandom_range(10000, 16000), $urandom_range(6000, 9000),
                      $urandom_range(0, 3000), $urandom_range(0, 1));
            if (ph == 0) hold_start = 1'b1;
            queue_frames(w, h, 1, 0);
            wait_idle();
        end

        $display("Sent %0d pixels over several sizes, weights and stall mixes;",
                 pixels_sent);
        $display("checked %0d words.", words_seen);
        if (errors == 0 && blur_expect.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
